// File: src/mcrt_pkg.sv
`default_nettype none

package mcrt_pkg;

	localparam int NUM_CHANNELS_DEF = 4;
	localparam int CHAN_W = 2;
	localparam int VAL_W = 16;
	localparam int TAG_W = 8;
	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef struct packed {
		logic              command;
		logic [CHAN_W-1:0] channel;
		logic [VAL_W-1:0]  start_value;
		logic [VAL_W-1:0]  target_value;
		logic [VAL_W-1:0]  step_size;
		logic [VAL_W-1:0]  reload_period;
		logic [TAG_W-1:0]  user_tag;
	} req_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [VAL_W-1:0]  ramp_value;
		logic [TAG_W-1:0]  out_tag;
		logic              finished;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	typedef struct packed {
		logic fire;
	} dp_status_t;

endpackage

`default_nettype wire

// File: src/multi_channel_ramp_timer_core.sv
// Bank of NUM_CHANNELS fade ramp channels. A start request loads one channel and
// the core stays idle. A tick request walks the channels one per cycle through a
// single shared step unit, pausing on a firing channel while the single result
// register is still waiting to be taken; each stepping channel gives one result,
// the final one of the tick marked last. The next request is taken once the walk
// is done, while the last result may still be waiting downstream.
`default_nettype none

module multi_channel_ramp_timer_core import mcrt_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	dp_cmd_t          cmd;
	dp_status_t       st;
	logic [IDX_W-1:0] idx;

	mcrt_ctrl #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.IDX_W(IDX_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_command(req.command),
		.req_stall(req_stall),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.st(st),
		.cmd(cmd),
		.idx(idx)
	);

	mcrt_datapath #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.IDX_W(IDX_W)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.idx(idx),
		.req(req),
		.st(st),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

// File: src/mcrt_datapath.sv
`default_nettype none

module mcrt_datapath import mcrt_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int IDX_W = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire logic [IDX_W-1:0] idx,
	input  wire req_t             req,
	output dp_status_t            st,
	output rsp_t                  rsp
);

	logic [NUM_CHANNELS-1:0] enabled_q;
	logic [VAL_W-1:0]        current_q [NUM_CHANNELS];
	logic [VAL_W-1:0]        goal_q    [NUM_CHANNELS];
	logic [VAL_W-1:0]        step_q    [NUM_CHANNELS];
	logic [VAL_W-1:0]        period_q  [NUM_CHANNELS];
	logic [VAL_W-1:0]        count_q   [NUM_CHANNELS];
	logic [TAG_W-1:0]        tag_q     [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] up_q;
	rsp_t                    rsp_q;

	logic [NUM_CHANNELS-1:0] fire_vec;
	logic [NUM_CHANNELS-1:0] load_hit;
	logic [NUM_CHANNELS-1:0] step_hit;
	logic [VAL_W:0]          up_sum;
	logic [VAL_W-1:0]        next_val;
	logic                    done;
	logic                    later;

	always_comb begin
		later = 1'b0;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			fire_vec[c] = enabled_q[c] && (count_q[c] == '0);
			load_hit[c] = cmd.load && (32'(req.channel) == c);
			step_hit[c] = cmd.step && (idx == IDX_W'(c));
			if (c > int'(idx)) begin
				later = later | fire_vec[c];
			end
		end
	end

	// saturating step toward the goal
	always_comb begin
		up_sum = {1'b0, current_q[idx]} + {1'b0, step_q[idx]};
		if (up_q[idx]) begin
			next_val = up_sum[VAL_W] ? VAL_MAX : up_sum[VAL_W-1:0];
			done = (next_val >= goal_q[idx]);
		end else begin
			next_val = (step_q[idx] > current_q[idx]) ? '0 : current_q[idx] - step_q[idx];
			done = (next_val <= goal_q[idx]);
		end
	end

	assign st.fire = fire_vec[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
		end else begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (load_hit[c]) begin
					enabled_q[c] <= 1'b1;
				end else if (step_hit[c] && fire_vec[c] && done) begin
					enabled_q[c] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (load_hit[c]) begin
				current_q[c] <= req.start_value;
				goal_q[c] <= req.target_value;
				step_q[c] <= req.step_size;
				period_q[c] <= req.reload_period;
				count_q[c] <= '0;
				tag_q[c] <= req.user_tag;
				up_q[c] <= (req.start_value < req.target_value);
			end else if (step_hit[c] && enabled_q[c]) begin
				if (count_q[c] != '0) begin
					count_q[c] <= count_q[c] - 1'b1;
				end else begin
					count_q[c] <= period_q[c];
					current_q[c] <= next_val;
				end
			end
		end
		if (cmd.step && st.fire) begin
			rsp_q.out_channel <= CHAN_W'(idx);
			rsp_q.ramp_value <= done ? goal_q[idx] : next_val;
			rsp_q.out_tag <= tag_q[idx];
			rsp_q.finished <= done;
			rsp_q.last <= !later;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// File: src/mcrt_ctrl.sv
`default_nettype none

module mcrt_ctrl import mcrt_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int IDX_W = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic             req_command,
	output logic                  req_stall,
	input  wire logic             rsp_stall,
	output logic                  rsp_valid,
	input  wire dp_status_t       st,
	output dp_cmd_t               cmd,
	output logic [IDX_W-1:0]      idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

	state_t           state_q;
	logic [IDX_W-1:0] idx_q;
	logic             rsp_valid_q;
	logic             out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cmd.load = (state_q == ST_IDLE) && req_valid && (req_command == CMD_START);
	assign cmd.step = (state_q == ST_SCAN) && (!st.fire || out_free);
	assign idx = idx_q;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.step && st.fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (req_valid && (req_command == CMD_TICK)) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cmd.step) begin
						if (idx_q == LAST_IDX) begin
							state_q <= ST_IDLE;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					idx_q <= '0;
				end
			endcase
		end
	end

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && st.fire |-> !rsp_valid_q || !rsp_stall)
		else $error("result register overwritten");

	a_fire_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && st.fire |=> rsp_valid_q)
		else $error("stepping channel gave no result");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && cmd.step && (idx_q == LAST_IDX) |=> (state_q == ST_IDLE))
		else $error("tick scan did not end");

	a_no_load_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.step && (state_q == ST_IDLE))
		else $error("start during tick scan");

endmodule

`default_nettype wire
